FILE: hdl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, register codes and fixed-point helpers of the box/plane
// contact generator.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned MaxContactsDef = 4;
  localparam int unsigned QueueDepth     = 2;
  localparam int unsigned CfgIdxW        = 8;

  localparam logic signed [31:0] QOne   = 32'sh4000_0000;
  localparam logic signed [31:0] S32Max = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32Min = 32'sh8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    RegNormX  = 8'd0,
    RegNormY  = 8'd1,
    RegNormZ  = 8'd2,
    RegOffset = 8'd3
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]         pad;
    logic [30:0]        half_z;
    logic [30:0]        half_y;
    logic [30:0]        half_x;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_w;
    logic signed [31:0] box_pos_z;
    logic signed [31:0] box_pos_y;
    logic signed [31:0] box_pos_x;
  } box_in_t;

  typedef struct packed {
    logic [5:0]         pad;
    logic [2:0]         corner_index;
    logic signed [31:0] contact_z;
    logic signed [31:0] contact_y;
    logic signed [31:0] contact_x;
    logic [30:0]        penetration_depth;
  } contact_t;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic signed [31:0] off;
  } plane_t;

  // Box position and the nine exact products of matrix entry by half extent.
  typedef struct packed {
    logic [2:0][31:0]      pos;
    logic [2:0][2:0][62:0] prod;
  } box_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'(S32Max)) begin
      r = S32Max;
    end else if (v < 40'(S32Min)) begin
      r = S32Min;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [33:0] mul30(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p[63:30];
  endfunction

endpackage

FILE: hdl/bpc_front.sv
// ----------------------------------------------------------------------------
// bpc_front
// Three-stage box front end: quaternion pair products, rotation matrix,
// matrix-by-half-extent products.
// ----------------------------------------------------------------------------
module bpc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bpc_pkg::box_in_t in_box_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bpc_pkg::box_t    out_box_o
);

  logic adv;
  logic v1_q, v2_q, v3_q;

  logic signed [33:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic [2:0][31:0]   pos1_q, pos2_q, pos3_q;
  logic [2:0][30:0]   half1_q, half2_q;
  logic signed [31:0] m_d [3][3];
  logic signed [31:0] m_q [3][3];
  logic [2:0][2:0][62:0] prod_d, prod_q;

  assign adv         = !v3_q || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = v3_q;
  assign out_box_o   = '{pos: pos3_q, prod: prod_q};

  always_comb begin
    m_d[0][0] = bpc_pkg::sat32(40'(37'(bpc_pkg::QOne) - ((37'(yy_q) + 37'(zz_q)) <<< 1)));
    m_d[0][1] = bpc_pkg::sat32(40'((37'(xy_q) - 37'(wz_q)) <<< 1));
    m_d[0][2] = bpc_pkg::sat32(40'((37'(xz_q) + 37'(wy_q)) <<< 1));
    m_d[1][0] = bpc_pkg::sat32(40'((37'(xy_q) + 37'(wz_q)) <<< 1));
    m_d[1][1] = bpc_pkg::sat32(40'(37'(bpc_pkg::QOne) - ((37'(xx_q) + 37'(zz_q)) <<< 1)));
    m_d[1][2] = bpc_pkg::sat32(40'((37'(yz_q) - 37'(wx_q)) <<< 1));
    m_d[2][0] = bpc_pkg::sat32(40'((37'(xz_q) - 37'(wy_q)) <<< 1));
    m_d[2][1] = bpc_pkg::sat32(40'((37'(yz_q) + 37'(wx_q)) <<< 1));
    m_d[2][2] = bpc_pkg::sat32(40'(37'(bpc_pkg::QOne) - ((37'(xx_q) + 37'(yy_q)) <<< 1)));
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j] = 63'(64'(m_q[i][j]) * 64'($signed({1'b0, half2_q[j]})));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xx_q    <= bpc_pkg::mul30(in_box_i.quat_x, in_box_i.quat_x);
      yy_q    <= bpc_pkg::mul30(in_box_i.quat_y, in_box_i.quat_y);
      zz_q    <= bpc_pkg::mul30(in_box_i.quat_z, in_box_i.quat_z);
      xy_q    <= bpc_pkg::mul30(in_box_i.quat_x, in_box_i.quat_y);
      xz_q    <= bpc_pkg::mul30(in_box_i.quat_x, in_box_i.quat_z);
      yz_q    <= bpc_pkg::mul30(in_box_i.quat_y, in_box_i.quat_z);
      wx_q    <= bpc_pkg::mul30(in_box_i.quat_w, in_box_i.quat_x);
      wy_q    <= bpc_pkg::mul30(in_box_i.quat_w, in_box_i.quat_y);
      wz_q    <= bpc_pkg::mul30(in_box_i.quat_w, in_box_i.quat_z);
      pos1_q  <= {in_box_i.box_pos_z, in_box_i.box_pos_y, in_box_i.box_pos_x};
      half1_q <= {in_box_i.half_z, in_box_i.half_y, in_box_i.half_x};
      m_q     <= m_d;
      pos2_q  <= pos1_q;
      half2_q <= half1_q;
      prod_q  <= prod_d;
      pos3_q  <= pos2_q;
    end
  end

endmodule

FILE: hdl/bpc_queue.sv
// ----------------------------------------------------------------------------
// bpc_queue
// Small register FIFO between the box front end and the corner back end.
// ----------------------------------------------------------------------------
module bpc_queue #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = bpc_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

FILE: hdl/bpc_back.sv
// ----------------------------------------------------------------------------
// bpc_back
// Corner lane: one corner per cycle while the output is not stalled, through
// world transform, plane distance and contact collection with last-contact marking.
// ----------------------------------------------------------------------------
module bpc_back #(
  parameter int unsigned MaxContacts = bpc_pkg::MaxContactsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bpc_pkg::plane_t     plane_i,
  input  logic                head_valid_i,
  input  bpc_pkg::box_t       head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bpc_pkg::contact_t   out_data_o,
  output logic                out_last_o
);

  localparam int unsigned CntW = $clog2(MaxContacts + 1);

  logic adv, take, consume, flush, out_free;
  logic is_ct, is_end, is_final, flush_last;

  logic [2:0]         k_q, k1_q, k2_q, k3_q, k4_q;
  logic               v1_q, v2_q, v3_q, v4_q;
  logic signed [33:0] term_d [3][3];
  logic signed [33:0] term_q [3][3];
  logic [2:0][31:0]   pos1_q;
  logic signed [31:0] wc_d [3];
  logic signed [31:0] wc2_q [3];
  logic signed [31:0] wc3_q [3];
  logic signed [31:0] wc4_q [3];
  logic signed [33:0] np_q [3];
  logic signed [35:0] s_d, s4_q;
  logic signed [36:0] ns;
  logic [CntW-1:0]    cnt_q;

  bpc_pkg::contact_t  new_ct;
  bpc_pkg::contact_t  pend_q, out_q;
  logic               pv_q, pl_q, ov_q, ol_q;

  assign take  = adv && head_valid_i;
  assign pop_o = take && (k_q == 3'd7);

  always_comb begin
    logic signed [63:0] p;
    logic               plus;
    for (int j = 0; j < 3; j++) begin
      plus = k_q[2-j];
      for (int i = 0; i < 3; i++) begin
        p = 64'($signed(head_i.prod[i][j]));
        term_d[i][j] = plus ? 34'(p >>> 30) : 34'((-p) >>> 30);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wc_d[i] = bpc_pkg::sat32(40'(36'($signed(pos1_q[i])) + 36'(term_q[i][0])
                                   + 36'(term_q[i][1]) + 36'(term_q[i][2])));
    end
  end

  assign s_d = 36'(np_q[0]) + 36'(np_q[1]) + 36'(np_q[2]) - 36'(plane_i.off);
  assign ns  = -37'(s4_q);

  assign is_ct    = v4_q && s4_q[35] && (cnt_q < CntW'(MaxContacts));
  assign is_end   = v4_q && (k4_q == 3'd7);
  assign is_final = is_ct && (cnt_q == CntW'(MaxContacts - 1));

  assign out_free   = !ov_q || out_ready_i;
  assign flush      = pv_q && out_free && (pl_q || is_ct || is_end);
  assign flush_last = pl_q || (is_end && !is_ct);
  assign consume    = v4_q && (!pv_q || flush || !(is_ct || is_end));
  assign adv        = !v4_q || consume;

  always_comb begin
    new_ct                   = '0;
    new_ct.penetration_depth = (ns > 37'sd2147483647) ? 31'h7fff_ffff : ns[30:0];
    new_ct.contact_x         = wc4_q[0];
    new_ct.contact_y         = wc4_q[1];
    new_ct.contact_z         = wc4_q[2];
    new_ct.corner_index      = k4_q;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;
  assign out_last_o  = ol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      cnt_q <= '0;
      pv_q  <= 1'b0;
      pl_q  <= 1'b0;
      ov_q  <= 1'b0;
      ol_q  <= 1'b0;
    end else begin
      if (take) begin
        k_q <= k_q + 1'b1;
      end
      if (adv) begin
        v1_q <= take;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
      end
      if (consume) begin
        if (is_end) begin
          cnt_q <= '0;
        end else if (is_ct) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (consume && is_ct) begin
        pv_q <= 1'b1;
        pl_q <= is_final || is_end;
      end else if (flush) begin
        pv_q <= 1'b0;
      end
      if (flush) begin
        ov_q <= 1'b1;
        ol_q <= flush_last;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      term_q <= term_d;
      pos1_q <= head_i.pos;
      k1_q   <= k_q;
      wc2_q  <= wc_d;
      k2_q   <= k1_q;
      for (int i = 0; i < 3; i++) begin
        np_q[i] <= bpc_pkg::mul30(i == 0 ? plane_i.nx : (i == 1 ? plane_i.ny : plane_i.nz),
                                  wc2_q[i]);
      end
      wc3_q  <= wc2_q;
      k3_q   <= k2_q;
      s4_q   <= s_d;
      wc4_q  <= wc3_q;
      k4_q   <= k3_q;
    end
    if (consume && is_ct) begin
      pend_q <= new_ct;
    end
    if (flush) begin
      out_q <= pend_q;
    end
  end

endmodule

FILE: hdl/box_plane_contact.sv
// ----------------------------------------------------------------------------
// box_plane_contact
// Box against static plane contact generator: up to MaxContacts corner
// contacts per box, plane held in configuration registers.
// ----------------------------------------------------------------------------
// Contacts: each is held until the next penetrating corner or the last corner of
//   its box, or until it is the box's MaxContacts-th contact.
// Throughput: the single corner lane evaluates one of the eight corners each
//   cycle while its output is not stalled; contacts leave at most one a cycle.
// Reset: asynchronous, active low; plane resets to normal (0, 1.0, 0) and
//   offset 0, queue and pipelines empty.
// ----------------------------------------------------------------------------
module box_plane_contact #(
  parameter int unsigned MaxContacts = bpc_pkg::MaxContactsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // box_pos_x, box_pos_y, box_pos_z, quat_w, quat_x, quat_y, quat_z,
  // half_x, half_y, half_z, zero pad
  input  logic [319:0]                s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // penetration_depth, contact_x, contact_y, contact_z, corner_index, zero pad
  output logic [135:0]                m_axis_tdata,
  output logic                        m_axis_tlast,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bpc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i
);

  bpc_pkg::plane_t   plane_q;
  bpc_pkg::box_t     f_box, q_head;
  bpc_pkg::contact_t out_data;
  logic              f_valid, q_full, q_empty, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q.nx  <= '0;
      plane_q.ny  <= bpc_pkg::QOne;
      plane_q.nz  <= '0;
      plane_q.off <= '0;
    end else if (cfg_valid_i) begin
      unique case (bpc_pkg::reg_idx_e'(cfg_index_i))
        bpc_pkg::RegNormX:  plane_q.nx  <= cfg_data_i;
        bpc_pkg::RegNormY:  plane_q.ny  <= cfg_data_i;
        bpc_pkg::RegNormZ:  plane_q.nz  <= cfg_data_i;
        bpc_pkg::RegOffset: plane_q.off <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_box_i    (bpc_pkg::box_in_t'(s_axis_tdata)),
    .out_valid_o (f_valid),
    .out_ready_i (!q_full),
    .out_box_o   (f_box)
  );

  bpc_queue #(
    .Width ($bits(bpc_pkg::box_t)),
    .Depth (bpc_pkg::QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_valid && !q_full),
    .push_data_i (f_box),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  bpc_back #(
    .MaxContacts (MaxContacts)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .plane_i      (plane_q),
    .head_valid_i (!q_empty),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (out_data),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = out_data;

endmodule

FILE: dv/tb_box_plane_contact.sv
// ----------------------------------------------------------------------------
// tb_box_plane_contact
// Self-checking bench for the box/plane contact generator: boxes are streamed
// in under random backpressure, every contact is predicted in fixed point and
// compared field by field, across several plane settings.
// ----------------------------------------------------------------------------
module tb_box_plane_contact;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxHits  = bpc_pkg::MaxContactsDef;
  localparam int Latency  = 100;
  localparam int Watchdog = 20000;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [319:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [135:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid_i, cfg_ready_o;
  logic [bpc_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  typedef struct {
    bpc_pkg::contact_t c;
    logic              last;
  } hit_t;

  bpc_pkg::box_in_t box_q[$];
  hit_t             hit_q[$];
  bpc_pkg::plane_t  plane;
  int               src_idle, snk_idle;
  int               errors, n_boxes, n_hits, quiet;
  logic             in_fire;

  box_plane_contact DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint floor30(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic predict_contacts(input bpc_pkg::box_in_t b);
    longint w, x, y, z, xx, yy, zz, xy, xz, yz, wx, wy, wz, s, acc;
    longint m[3][3];
    longint p[3], h[3], loc[3], wc[3];
    int cnt;
    hit_t e;
    w = b.quat_w; x = b.quat_x; y = b.quat_y; z = b.quat_z;
    p[0] = b.box_pos_x; p[1] = b.box_pos_y; p[2] = b.box_pos_z;
    h[0] = b.half_x; h[1] = b.half_y; h[2] = b.half_z;
    xx = floor30(x, x); yy = floor30(y, y); zz = floor30(z, z);
    xy = floor30(x, y); xz = floor30(x, z); yz = floor30(y, z);
    wx = floor30(w, x); wy = floor30(w, y); wz = floor30(w, z);
    m[0][0] = clamp32(64'sd1073741824 - 2 * (yy + zz));
    m[0][1] = clamp32(2 * (xy - wz));
    m[0][2] = clamp32(2 * (xz + wy));
    m[1][0] = clamp32(2 * (xy + wz));
    m[1][1] = clamp32(64'sd1073741824 - 2 * (xx + zz));
    m[1][2] = clamp32(2 * (yz - wx));
    m[2][0] = clamp32(2 * (xz - wy));
    m[2][1] = clamp32(2 * (yz + wx));
    m[2][2] = clamp32(64'sd1073741824 - 2 * (xx + yy));
    cnt = 0;
    for (int k = 0; k < 8 && cnt < MaxHits; k++) begin
      loc[0] = k[2] ? h[0] : -h[0];
      loc[1] = k[1] ? h[1] : -h[1];
      loc[2] = k[0] ? h[2] : -h[2];
      for (int i = 0; i < 3; i++) begin
        acc = p[i];
        for (int j = 0; j < 3; j++) acc += floor30(m[i][j], loc[j]);
        wc[i] = clamp32(acc);
      end
      s = floor30(longint'(plane.nx), wc[0]) + floor30(longint'(plane.ny), wc[1])
        + floor30(longint'(plane.nz), wc[2]) - longint'(plane.off);
      if (s < 0) begin
        e.c = '0;
        e.c.penetration_depth = 31'(clamp32(-s));
        e.c.contact_x = 32'(wc[0]);
        e.c.contact_y = 32'(wc[1]);
        e.c.contact_z = 32'(wc[2]);
        e.c.corner_index = 3'(k);
        e.last = 1'b0;
        hit_q.push_back(e);
        cnt++;
      end
    end
    if (cnt > 0) hit_q[$].last = 1'b1;
  endtask

  // driver
  always @(negedge clk_i) begin
    if (in_fire) begin
      predict_contacts(box_q.pop_front());
    end
    if (box_q.size() > 0 &&
        ((s_axis_tvalid && !in_fire) || $urandom_range(99) >= src_idle)) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= box_q[0];
    end else begin
      s_axis_tvalid <= 1'b0;
    end
    m_axis_tready <= ($urandom_range(99) >= snk_idle);
  end

  // monitor
  always @(posedge clk_i) begin
    bpc_pkg::contact_t got;
    hit_t              want;
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (s_axis_tvalid && s_axis_tready) n_boxes <= n_boxes + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        n_hits <= n_hits + 1;
        if (hit_q.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: unexpected contact %h last %b", $time, got, m_axis_tlast);
        end else begin
          want = hit_q.pop_front();
          if (got.penetration_depth !== want.c.penetration_depth ||
              got.contact_x !== want.c.contact_x || got.contact_y !== want.c.contact_y ||
              got.contact_z !== want.c.contact_z ||
              got.corner_index !== want.c.corner_index || m_axis_tlast !== want.last) begin
            errors <= errors + 1;
            $display("%0t: mismatch exp %h/%b act %h/%b", $time, want.c, want.last,
                     got, m_axis_tlast);
          end
        end
      end
      if (quiet >= Watchdog) begin
        $display("%0t: watchdog expired", $time);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic bpc_pkg::box_in_t rand_box(input int mode);
    bpc_pkg::box_in_t b;
    logic [31:0] r[10];
    for (int i = 0; i < 10; i++) r[i] = $urandom();
    b = {3'b0, r[9][30:0], r[8][30:0], r[7][30:0], r[6], r[5], r[4], r[3], r[2], r[1], r[0]};
    if (mode != 0) begin
      // random quaternion components within about +-1.0, modest box near the plane
      b.quat_w = 32'($signed($urandom_range(2000)) - 1000) <<< 20;
      b.quat_x = 32'($signed($urandom_range(2000)) - 1000) <<< 20;
      b.quat_y = 32'($signed($urandom_range(2000)) - 1000) <<< 20;
      b.quat_z = 32'($signed($urandom_range(2000)) - 1000) <<< 20;
      b.box_pos_x = 32'($signed($urandom_range(1 << 22)) - (1 << 21));
      b.box_pos_y = 32'($signed($urandom_range(1 << 22)) - (1 << 21));
      b.box_pos_z = 32'($signed($urandom_range(1 << 22)) - (1 << 21));
      b.half_x = 31'($urandom_range(1 << 20));
      b.half_y = 31'($urandom_range(1 << 20));
      b.half_z = 31'($urandom_range(1 << 20));
    end
    return b;
  endfunction

  task automatic write_reg(input bpc_pkg::reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == bpc_pkg::RegNormX) plane.nx = val;
    if (idx == bpc_pkg::RegNormY) plane.ny = val;
    if (idx == bpc_pkg::RegNormZ) plane.nz = val;
    if (idx == bpc_pkg::RegOffset) plane.off = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain;
    while (box_q.size() > 0 || s_axis_tvalid || hit_q.size() > 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  initial begin
    bpc_pkg::box_in_t b;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    errors = 0; n_boxes = 0; n_hits = 0; quiet = 0;
    src_idle = 37; snk_idle = 69;
    plane = '{nx: 32'sd0, ny: bpc_pkg::QOne, nz: 32'sd0, off: 32'sd0};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: identity boxes straddling the default plane, extremes
    b = '0; b.quat_w = bpc_pkg::QOne;
    b.half_x = 31'h10000; b.half_y = 31'h10000; b.half_z = 31'h10000;
    box_q.push_back(b);
    b.box_pos_y = 32'sh10000; box_q.push_back(b);
    b.box_pos_y = -32'sh20000; box_q.push_back(b);
    b.box_pos_y = 32'sh8000; box_q.push_back(b);
    b = '0; b.quat_w = bpc_pkg::QOne; box_q.push_back(b);
    b.box_pos_y = -32'sd1; box_q.push_back(b);
    b = '0; b.quat_w = bpc_pkg::QOne; b.half_x = '1; b.half_y = '1; b.half_z = '1;
    box_q.push_back(b);
    b.box_pos_x = bpc_pkg::S32Max; b.box_pos_y = bpc_pkg::S32Min;
    b.box_pos_z = bpc_pkg::S32Max; box_q.push_back(b);
    b.quat_w = bpc_pkg::S32Min; b.quat_x = bpc_pkg::S32Max;
    b.quat_y = bpc_pkg::S32Min; b.quat_z = bpc_pkg::S32Max;
    box_q.push_back(b);
    b = '1; b.pad = '0; box_q.push_back(b);
    b = '0; b.quat_x = bpc_pkg::QOne; b.half_y = 31'h4000; b.box_pos_y = 32'sh1000;
    box_q.push_back(b);
    b = '0; b.quat_w = 32'sh2d41_3ccd; b.quat_z = 32'sh2d41_3ccd;
    b.half_x = 31'h20000; b.half_y = 31'h10000; b.half_z = 31'h8000; box_q.push_back(b);
    drain();

    // several planes, extremes among them, phased idling
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(bpc_pkg::RegNormX, 32'sd0);
                 write_reg(bpc_pkg::RegNormY, bpc_pkg::QOne);
                 write_reg(bpc_pkg::RegNormZ, 32'sd0);
                 write_reg(bpc_pkg::RegOffset, 32'sd0); end
        1: begin write_reg(bpc_pkg::RegNormX, bpc_pkg::S32Max);
                 write_reg(bpc_pkg::RegNormY, bpc_pkg::S32Min);
                 write_reg(bpc_pkg::RegNormZ, bpc_pkg::S32Max);
                 write_reg(bpc_pkg::RegOffset, bpc_pkg::S32Min); end
        2: begin write_reg(bpc_pkg::RegNormX, 32'sh2d41_3ccd);
                 write_reg(bpc_pkg::RegNormY, 32'sh2d41_3ccd);
                 write_reg(bpc_pkg::RegNormZ, 32'sd0);
                 write_reg(bpc_pkg::RegOffset, bpc_pkg::S32Max); end
        3: begin write_reg(bpc_pkg::RegNormX, 32'sd0);
                 write_reg(bpc_pkg::RegNormY, 32'sd0);
                 write_reg(bpc_pkg::RegNormZ, -bpc_pkg::QOne);
                 write_reg(bpc_pkg::RegOffset, 32'sh10000); end
        default: begin write_reg(bpc_pkg::RegNormX, $urandom());
                 write_reg(bpc_pkg::RegNormY, $urandom());
                 write_reg(bpc_pkg::RegNormZ, $urandom());
                 write_reg(bpc_pkg::RegOffset, $urandom()); end
      endcase
      if (ph == 2) begin src_idle = 69; snk_idle = 37; end
      if (ph == 4) begin src_idle = 0; snk_idle = 0; end
      for (int i = 0; i < 43; i++) box_q.push_back(rand_box($urandom_range(3)));
      drain();
    end

    $display("Covered %0d boxes and %0d contacts over six plane settings", n_boxes, n_hits);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/bpc_pkg.sv
hdl/bpc_front.sv
hdl/bpc_queue.sv
hdl/bpc_back.sv
hdl/box_plane_contact.sv
dv/tb_box_plane_contact.sv
